// ===== sv/gtb_pkg.sv =====
// Shared types, constants and codes for the 3x3 blur and threshold block.
`timescale 1ns / 1ps
`default_nettype none

package gtb_pkg;

  // Line store depth default and field widths
  localparam int MAX_WIDTH_DEF = 16384;
  localparam int COL_W         = 15;
  localparam int ROW_W         = 16;
  localparam int PIX_W         = 8;
  localparam int THR_W         = 8;
  localparam int SUM_W         = 12;
  localparam int BLUR_SHIFT    = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [COL_W-1:0] WIDTH_RST     = 15'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RST    = 16'd480;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd128;

  // Result pixel values
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  // Queue depths (powers of two)
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [PIX_W-1:0] gray_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] binary_pixel;
    logic             frame_end;
  } out_item_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic             is_drain;
    logic             last;
    logic             emit_win;
    logic             win_full;
    logic             emit_sfx;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } cmd_t;

  // One output queue entry holds the one or two results of a request
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } out_entry_t;

endpackage

`default_nettype wire

// ===== sv/gtb_front.sv =====
// Front end: configuration registers, raster counters and request classification.
`timescale 1ns / 1ps
`default_nettype none

module gtb_front import gtb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_take,
  input  in_item_t              in_item,
  output logic                  cmd_push,
  output cmd_t                  cmd,
  output logic [THR_W-1:0]      threshold
);

  localparam logic [COL_W-1:0] MAXW_M1 = COL_W'(MAX_WIDTH - 1);

  logic [COL_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic [THR_W-1:0] thresh_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] drain_cnt_r, drain_cnt_nxt;
  logic             draining_r, draining_nxt;

  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic             is_drain, row_end, last_row, drain_last;

  assign cfg_ready = 1'b1;
  assign threshold = thresh_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      thresh_r <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[COL_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        REG_THRESHOLD:    thresh_r <= cfg_data[THR_W-1:0];
        default:          ;
      endcase
    end
  end

  // Width and height in use, minus one
  always_comb begin
    if (width_r == '0) begin
      w_m1 = '0;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_m1 = MAXW_M1;
    end else begin
      w_m1 = width_r - 1'b1;
    end
    h_m1 = (height_r == '0) ? '0 : height_r - 1'b1;
  end

  assign is_drain   = (in_item.opcode == OP_DRAIN);
  assign row_end    = (col_r >= w_m1);
  assign last_row   = (row_r >= h_m1);
  assign drain_last = (drain_cnt_r >= w_m1);

  // Classify the request for the back end
  always_comb begin
    cmd.is_drain = is_drain;
    cmd.last     = drain_last;
    cmd.emit_win = !is_drain && (row_r != '0) && (col_r != '0);
    cmd.win_full = (row_r >= 16'd2) && (col_r >= 15'd2);
    cmd.emit_sfx = !is_drain && row_end && (row_r != '0);
    cmd.col      = col_r;
    cmd.pixel    = in_item.gray_pixel;
    cmd_push     = in_take && (is_drain ? draining_r : !draining_r);
  end

  // Advance the raster position
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    drain_cnt_nxt = drain_cnt_r;
    draining_nxt  = draining_r;
    if (in_take) begin
      if (is_drain) begin
        if (draining_r) begin
          if (drain_last) begin
            col_nxt       = '0;
            row_nxt       = '0;
            drain_cnt_nxt = '0;
            draining_nxt  = 1'b0;
          end else begin
            drain_cnt_nxt = drain_cnt_r + 1'b1;
          end
        end
      end else if (!draining_r) begin
        if (row_end) begin
          col_nxt = '0;
          if (last_row) begin
            draining_nxt  = 1'b1;
            drain_cnt_nxt = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      drain_cnt_r <= '0;
      draining_r  <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      draining_r  <= draining_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gtb_cmd_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module gtb_cmd_queue import gtb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic q_full,
  input  logic q_pop,
  output logic q_empty,
  output cmd_t head
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(q_pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/gtb_back.sv =====
// Back end: line stores, 3x3 window, Gaussian sum and threshold.
`timescale 1ns / 1ps
`default_nettype none

module gtb_back import gtb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmdq_empty,
  input  cmd_t                  cmdq_head,
  output logic                  cmdq_pop,
  input  logic [THR_W-1:0]      threshold,
  input  logic [OUTQ_CNT_W-1:0] outq_count,
  output logic                  outq_push,
  output out_entry_t            outq_entry
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // Line stores
  logic [PIX_W-1:0] older_row_r [MAX_WIDTH];
  logic [PIX_W-1:0] prior_row_r [MAX_WIDTH];
  logic [PIX_W-1:0] older_q_r, prior_q_r;

  logic [ADDR_W-1:0] addr0, addr1;
  logic              s1_v_r, s2_v_r;
  cmd_t              s1_cmd_r, s2_cmd_r;
  logic              s1_wr;
  logic              fwd_hit_r;
  logic [PIX_W-1:0]  fwd_older_r, fwd_prior_r;
  logic [PIX_W-1:0]  older_e, prior_e;
  logic [PIX_W-1:0]  win_r [3][3];
  logic [SUM_W-1:0]  sum;
  logic [PIX_W-1:0]  blurred, win_pix;

  // Take a request when the output queue has room for everything in flight
  assign cmdq_pop = !cmdq_empty &&
                    ((32'(outq_count) + 32'(s1_v_r) + 32'(s2_v_r)) < 32'(OUTQ_DEPTH));

  assign addr0 = ADDR_W'(cmdq_head.col);
  assign addr1 = ADDR_W'(s1_cmd_r.col);
  assign s1_wr = s1_v_r && !s1_cmd_r.is_drain;

  // Bypass the store when the previous request wrote the same column
  assign older_e = fwd_hit_r ? fwd_older_r : older_q_r;
  assign prior_e = fwd_hit_r ? fwd_prior_r : prior_q_r;

  // Read at issue, rotate the column at the next stage
  always_ff @(posedge clk) begin
    if (cmdq_pop) begin
      older_q_r <= older_row_r[addr0];
      prior_q_r <= prior_row_r[addr0];
    end
    if (s1_wr) begin
      older_row_r[addr1] <= prior_e;
      prior_row_r[addr1] <= s1_cmd_r.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (cmdq_pop) begin
      fwd_hit_r <= s1_wr && (addr1 == addr0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmdq_pop) begin
      fwd_older_r <= prior_e;
      fwd_prior_r <= s1_cmd_r.pixel;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmdq_pop;
      s2_v_r <= s1_v_r;
    end
  end

  // Stage payloads and window shift
  always_ff @(posedge clk) begin
    if (cmdq_pop) begin
      s1_cmd_r <= cmdq_head;
    end
    if (s1_v_r) begin
      s2_cmd_r <= s1_cmd_r;
    end
    if (s1_wr) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= older_e;
      win_r[1][2] <= prior_e;
      win_r[2][2] <= s1_cmd_r.pixel;
    end
  end

  // 1-2-1 / 2-4-2 / 1-2-1 sum, then threshold
  always_comb begin
    sum = SUM_W'(win_r[0][0]) + (SUM_W'(win_r[0][1]) << 1) + SUM_W'(win_r[0][2]) +
          (SUM_W'(win_r[1][0]) << 1) + (SUM_W'(win_r[1][1]) << 2) +
          (SUM_W'(win_r[1][2]) << 1) +
          SUM_W'(win_r[2][0]) + (SUM_W'(win_r[2][1]) << 1) + SUM_W'(win_r[2][2]);
    blurred = sum[SUM_W-1:BLUR_SHIFT];
    win_pix = (s2_cmd_r.win_full && (blurred <= threshold)) ? PIX_WHITE : PIX_BLACK;
  end

  // Pack the results of one request into a queue entry
  always_comb begin
    outq_entry.two             = s2_cmd_r.emit_win && s2_cmd_r.emit_sfx;
    outq_entry.r0.binary_pixel = s2_cmd_r.emit_win ? win_pix : PIX_BLACK;
    outq_entry.r0.frame_end    = s2_cmd_r.is_drain && s2_cmd_r.last;
    outq_entry.r1.binary_pixel = PIX_BLACK;
    outq_entry.r1.frame_end    = 1'b0;
    outq_push = s2_v_r && (s2_cmd_r.is_drain || s2_cmd_r.emit_win || s2_cmd_r.emit_sfx);
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    outq_push |-> (32'(outq_count) < 32'(OUTQ_DEPTH)))
    else $error("result written into a full output queue");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(outq_count) + 32'(s1_v_r) + 32'(s2_v_r)) <= 32'(OUTQ_DEPTH))
    else $error("requests in flight exceed output queue room");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_pop |-> !cmdq_empty)
    else $error("request taken from an empty queue");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && fwd_hit_r) |-> $past(s1_wr))
    else $error("bypass used without a store write the cycle before");

endmodule

`default_nettype wire

// ===== sv/gtb_out_queue.sv =====
// Output queue of result entries, each holding one or two result pixels.
`timescale 1ns / 1ps
`default_nettype none

module gtb_out_queue import gtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  out_entry_t            push_entry,
  output logic [OUTQ_CNT_W-1:0] count,
  input  logic                  pop,
  output logic                  empty,
  output out_item_t             out_data
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);

  out_entry_t       ent_r [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0] cnt_r;
  logic             sel_r;
  out_entry_t       head;
  logic             pop_ok, head_done;

  assign count     = cnt_r;
  assign empty     = (cnt_r == '0);
  assign head      = ent_r[rd_ptr_r];
  assign out_data  = sel_r ? head.r1 : head.r0;
  assign pop_ok    = pop && !empty;
  assign head_done = pop_ok && (sel_r || !head.two);

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

  // Step through the results of the head entry, then drop it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sel_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (head_done) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        sel_r <= !head_done;
      end
      cnt_r <= cnt_r + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(head_done);
    end
  end

endmodule

`default_nettype wire

// ===== sv/gaussian3x3_threshold_binarizer.sv =====
// Top level: 3x3 Gaussian blur with inverse binary threshold on a pixel stream.
//
// Input side is a queue: drive in_data and push while full is low; the request
// is taken at that edge. opcode OP_PIXEL carries one raster pixel in row-major
// order, opcode OP_DRAIN emits one pixel of the final all-zero row.
// Result side is a queue: while empty is low, out_data holds the oldest result;
// pop takes it. frame_end marks the last drain pixel of a frame.
// Configuration: cfg_valid with cfg_index/cfg_data writes image width, height
// or threshold; cfg_ready is always high. Write only while the block is idle.
// A request passes the request queue, back-end stages s1 and s2, then the output queue.
// Throughput: one request per cycle while the output queue has room; a request at
// a row end may yield two results, which leave at one per cycle through the output queue.
// The four-entry output queue and the in-flight count set when the back end
// stalls: with the receiver stalled, the request queue fills and full rises.
// Reset clears counters and queues and loads width 640, height 480, threshold
// 128; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gaussian3x3_threshold_binarizer import gtb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  in_take;
  logic                  cmd_push, cmdq_empty, cmdq_pop;
  cmd_t                  cmd, cmdq_head;
  logic [THR_W-1:0]      threshold;
  logic [OUTQ_CNT_W-1:0] outq_count;
  logic                  outq_push;
  out_entry_t            outq_entry;

  assign in_take = push && !full;

  gtb_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .in_item   (in_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .threshold (threshold)
  );

  gtb_cmd_queue u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd),
    .q_full    (full),
    .q_pop     (cmdq_pop),
    .q_empty   (cmdq_empty),
    .head      (cmdq_head)
  );

  gtb_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmdq_empty (cmdq_empty),
    .cmdq_head  (cmdq_head),
    .cmdq_pop   (cmdq_pop),
    .threshold  (threshold),
    .outq_count (outq_count),
    .outq_push  (outq_push),
    .outq_entry (outq_entry)
  );

  gtb_out_queue u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (outq_push),
    .push_entry (outq_entry),
    .count      (outq_count),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/gaussian3x3_threshold_binarizer_test.sv =====
// Self-checking testbench for the 3x3 blur and inverse threshold binarizer.
`timescale 1ns / 1ps

module gaussian3x3_threshold_binarizer_test;
  import gtb_pkg::*;

  localparam int SETTLE     = 12;    // quiet cycles before a register write
  localparam int RAND_BEATS = 1400;  // random requests that move the frame
  localparam int TAIL_BEATS = 200;   // closing stretch without idling
  localparam int LINE_AW    = $clog2(MAX_WIDTH_DEF);

  typedef enum logic [1:0] {
    ST_REQ,
    ST_CFG,
    ST_HOLD
  } stim_kind_t;

  typedef struct {
    stim_kind_t            kind;
    in_item_t              req;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]            lvl;
  } stim_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  in_item_t              in_data   = '0;
  logic                  pop       = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  full;
  logic                  empty;
  logic                  cfg_ready;
  out_item_t             out_data;

  gaussian3x3_threshold_binarizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending stimulus and the expected result pixels
  stim_t     pending[$];
  out_item_t expected_pixels[$];
  int        results_owed = 0;
  int        fail_cnt     = 0;
  logic [1:0] lvl_now     = 2'd0;

  // Predictor state: registers, line stores, window, frame position
  logic [COL_W-1:0] cur_width  = WIDTH_RST;
  logic [ROW_W-1:0] cur_height = HEIGHT_RST;
  logic [THR_W-1:0] cur_thresh = THRESHOLD_RST;
  bit [PIX_W-1:0]   older_line [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]   prior_line [MAX_WIDTH_DEF];
  bit [PIX_W-1:0]   blur_win [3][3];  // [row: 0 oldest][col: 0 left]
  bit [ROW_W-1:0]   at_row;
  bit [COL_W-1:0]   at_col;
  bit [COL_W-1:0]   drain_pos;
  bit               in_drain;

  // Frame position as planned by the stimulus builder
  int         plan_w = 640;
  int         plan_h = 480;
  int         plan_row, plan_col, plan_drain, plan_beats;
  bit         plan_draining;
  logic [7:0] plan_thr = THRESHOLD_RST;

  function automatic int eff_width(logic [COL_W-1:0] wr);
    if (wr == 0) return 1;
    if (wr > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(wr);
  endfunction

  function automatic int eff_height(logic [ROW_W-1:0] hr);
    return (hr == 0) ? 1 : int'(hr);
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:  cur_width  = data[COL_W-1:0];
      REG_IMAGE_HEIGHT: cur_height = data[ROW_W-1:0];
      REG_THRESHOLD:    cur_thresh = data[THR_W-1:0];
      default: ;
    endcase
  endfunction

  // Work out the binarized pixels that one request yields
  function automatic void predict_binarized(in_item_t rq);
    int             w;
    int unsigned    wsum;
    out_item_t      res;
    logic [COL_W-1:0] c;
    bit [PIX_W-1:0] up2, up1;
    w = eff_width(cur_width);
    res.binary_pixel = PIX_BLACK;
    res.frame_end    = 1'b0;
    if (rq.opcode == OP_DRAIN) begin
      // drain tick: one pixel of the closing zero row, ignored outside the drain
      if (in_drain) begin
        res.frame_end = (drain_pos >= w - 1);
        expected_pixels.push_back(res);
        if (res.frame_end) begin
          blur_win  = '{default: '0};
          at_row    = '0;
          at_col    = '0;
          drain_pos = '0;
          in_drain  = 1'b0;
        end else begin
          drain_pos++;
        end
      end
    end else if (!in_drain) begin
      // shift the window left and load the new column from the line stores
      c   = at_col;
      up2 = older_line[c[LINE_AW-1:0]];
      up1 = prior_line[c[LINE_AW-1:0]];
      for (int k = 0; k < 3; k++) begin
        blur_win[k][0] = blur_win[k][1];
        blur_win[k][1] = blur_win[k][2];
      end
      blur_win[0][2] = up2;
      blur_win[1][2] = up1;
      blur_win[2][2] = rq.gray_pixel;
      older_line[c[LINE_AW-1:0]] = up1;
      prior_line[c[LINE_AW-1:0]] = rq.gray_pixel;
      // raw row 0 and column 0 give nothing; an incomplete window gives black
      if (at_row >= 1 && c >= 1) begin
        if (at_row >= 2 && c >= 2) begin
          wsum = blur_win[0][0] + 2 * blur_win[0][1] + blur_win[0][2]
               + 2 * blur_win[1][0] + 4 * blur_win[1][1] + 2 * blur_win[1][2]
               + blur_win[2][0] + 2 * blur_win[2][1] + blur_win[2][2];
          if (((wsum % (1 << SUM_W)) >> BLUR_SHIFT) <= cur_thresh)
            res.binary_pixel = PIX_WHITE;
        end
        expected_pixels.push_back(res);
      end
      // close the row with a black suffix pixel, then advance row or start drain
      if (c >= w - 1) begin
        if (at_row >= 1) begin
          res.binary_pixel = PIX_BLACK;
          expected_pixels.push_back(res);
        end
        at_col = '0;
        if (at_row >= eff_height(cur_height) - 1) begin
          in_drain  = 1'b1;
          drain_pos = '0;
        end else begin
          at_row++;
        end
      end else begin
        at_col = c + 1'b1;
      end
    end
  endfunction

  // Queue one request and track where it leaves the frame
  function automatic bit add_req(opcode_t op, logic [PIX_W-1:0] pix, logic [1:0] lvl);
    stim_t s;
    bit    last;
    s.kind           = ST_REQ;
    s.req.opcode     = op;
    s.req.gray_pixel = pix;
    s.idx            = REG_IMAGE_WIDTH;
    s.data           = '0;
    s.lvl            = lvl;
    pending.push_back(s);
    last = 1'b0;
    if (op == OP_DRAIN) begin
      if (plan_draining) begin
        plan_beats++;
        if (plan_drain >= plan_w - 1) begin
          last          = 1'b1;
          plan_draining = 1'b0;
          plan_row      = 0;
          plan_col      = 0;
          plan_drain    = 0;
        end else begin
          plan_drain++;
        end
      end
    end else if (!plan_draining) begin
      plan_beats++;
      if (plan_col >= plan_w - 1) begin
        plan_col = 0;
        if (plan_row >= plan_h - 1) begin
          plan_draining = 1'b1;
          plan_drain    = 0;
        end else begin
          plan_row++;
        end
      end else begin
        plan_col++;
      end
    end
    return last;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_t s;
    s.kind = ST_CFG;
    s.req  = '0;
    s.idx  = idx;
    s.data = data;
    s.lvl  = 2'd0;
    pending.push_back(s);
    case (idx)
      REG_IMAGE_WIDTH:  plan_w   = eff_width(data[COL_W-1:0]);
      REG_IMAGE_HEIGHT: plan_h   = eff_height(data);
      REG_THRESHOLD:    plan_thr = data[THR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_hold();
    stim_t s;
    s.kind = ST_HOLD;
    s.req  = '0;
    s.idx  = REG_IMAGE_WIDTH;
    s.data = '0;
    s.lvl  = 2'd0;
    pending.push_back(s);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int mode);
    int v;
    case (mode)
      0: return PIX_W'($urandom_range(0, 255));
      1: begin
        // hover around the threshold so both outcomes show up
        v = int'(plan_thr) + int'($urandom_range(0, 24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
      end
      default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Finish the open frame with pixels, then drain ticks
  function automatic void add_frame(int mode, logic [1:0] lvl, bit mid_events);
    bit done;
    done = 1'b0;
    while (!done) begin
      if (mid_events) begin
        case ($urandom_range(0, 299))
          0, 1: add_cfg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
          2:    add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
          // raise the width only where no unwritten line entry gets read
          3:    add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'((plan_draining || plan_row == 0) ?
                        $urandom_range(0, 40) : $urandom_range(0, plan_w)));
          4:    add_hold();
          default: ;
        endcase
      end
      // stray request that the block must drop
      if ($urandom_range(0, 31) == 0) begin
        if (plan_draining) void'(add_req(OP_PIXEL, PIX_W'($urandom_range(0, 255)), lvl));
        else void'(add_req(OP_DRAIN, PIX_W'($urandom_range(0, 255)), lvl));
      end
      if (plan_draining) done = add_req(OP_DRAIN, PIX_W'($urandom_range(0, 255)), lvl);
      else void'(add_req(OP_PIXEL, pick_pixel(mode), lvl));
    end
  endfunction

  function automatic int pick_idle(logic [1:0] lvl);
    case (lvl)
      2'd0: return 0;
      2'd1: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
      default: return ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : 0;
    endcase
  endfunction

  // Driver: issue requests and register writes from the pending queue
  int gap_left = 0;
  int quiet    = 0;

  always @(posedge clk) begin
    logic send, cfg_send;
    if (!rst_n) begin
      push      <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left  = 0;
      quiet     = 0;
    end else begin
      send     = push && full;
      cfg_send = cfg_valid && !cfg_ready;
      // count cycles with nothing in flight toward the block
      if (!push && !cfg_valid && results_owed == 0) begin
        if (quiet < SETTLE) quiet++;
      end else begin
        quiet = 0;
      end
      if (!send && !cfg_send && pending.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending[0].kind == ST_REQ) begin
          send     = 1'b1;
          in_data  <= pending[0].req;
          lvl_now  <= pending[0].lvl;
          gap_left = pick_idle(pending[0].lvl);
          void'(pending.pop_front());
        end else if (quiet >= SETTLE) begin
          // block is idle: write the register or just release the hold
          if (pending[0].kind == ST_CFG) begin
            cfg_send = 1'b1;
            cfg_index <= pending[0].idx;
            cfg_data  <= pending[0].data;
          end
          quiet = 0;
          void'(pending.pop_front());
        end
      end
      push      <= send;
      cfg_valid <= cfg_send;
    end
  end

  // Monitor: predict on accepted requests, check accepted results, drive pop
  int stall_left = 0;

  always @(posedge clk) begin
    out_item_t want;
    int        n_stall;
    if (!rst_n) begin
      pop        <= 1'b0;
      stall_left = 0;
    end else begin
      if (push && !full) predict_binarized(in_data);
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing expected: binary_pixel %0d frame_end %0b",
                 out_data.binary_pixel, out_data.frame_end);
          fail_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.binary_pixel !== want.binary_pixel) begin
            $error("binary_pixel: expected %0d, actual %0d",
                   want.binary_pixel, out_data.binary_pixel);
            fail_cnt++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_data.frame_end);
            fail_cnt++;
          end
        end
      end
      // hold pop low through random stall bursts
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        n_stall = pick_idle(lvl_now);
        if (n_stall != 0) begin
          stall_left = n_stall - 1;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
      results_owed <= expected_pixels.size();
    end
  end

  initial begin
    int         v, mode;
    logic [1:0] lvl;

    // Directed: stray drain tick, then a small checkerboard frame at threshold 255
    void'(add_req(OP_DRAIN, 8'hA5, 2'd1));
    add_cfg(REG_IMAGE_WIDTH, 16'd4);
    add_cfg(REG_IMAGE_HEIGHT, 16'd3);
    add_cfg(REG_THRESHOLD, 16'd255);
    for (int i = 0; i < 12; i++) begin
      void'(add_req(OP_PIXEL, (((i + i / 4) % 2) != 0) ? 8'hFF : 8'h00, 2'd1));
      if (i == 6) add_hold();
    end
    void'(add_req(OP_PIXEL, 8'h5A, 2'd1));
    repeat (4) void'(add_req(OP_DRAIN, 8'hFF, 2'd1));

    // Width zero clamps to one column; threshold 0
    add_cfg(REG_IMAGE_WIDTH, 16'd0);
    add_cfg(REG_IMAGE_HEIGHT, 16'd2);
    add_cfg(REG_THRESHOLD, 16'd0);
    void'(add_req(OP_PIXEL, 8'hFF, 2'd0));
    void'(add_req(OP_PIXEL, 8'h00, 2'd0));
    void'(add_req(OP_DRAIN, 8'h00, 2'd0));

    // Tallest height, cut short in mid-frame by height zero
    add_cfg(REG_IMAGE_HEIGHT, 16'hFFFF);
    add_cfg(REG_IMAGE_WIDTH, 16'd3);
    repeat (8) void'(add_req(OP_PIXEL, 8'h00, 2'd2));
    add_cfg(REG_IMAGE_HEIGHT, 16'd0);
    void'(add_req(OP_PIXEL, 8'h00, 2'd2));
    repeat (3) void'(add_req(OP_DRAIN, 8'h00, 2'd2));

    // Width register beyond the store size, then narrowed to end the long first row
    add_cfg(REG_IMAGE_WIDTH, 16'hFFFF);
    add_cfg(REG_IMAGE_HEIGHT, 16'd3);
    add_cfg(REG_THRESHOLD, 16'd120);
    repeat (40) void'(add_req(OP_PIXEL, pick_pixel(1), 2'd0));
    add_cfg(REG_IMAGE_WIDTH, 16'd6);
    add_frame(1, 2'd0, 1'b0);

    // Random frames, mostly small, with occasional register changes in mid-frame
    plan_beats = 0;
    while (plan_beats < RAND_BEATS) begin
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 19))
          0:          v = 0;
          1, 2, 3, 4: v = $urandom_range(9, 40);
          default:    v = $urandom_range(1, 8);
        endcase
        add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(v));
      end
      if ($urandom_range(0, 1) != 0)
        add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 7))
          0:       v = 0;
          1:       v = 255;
          default: v = $urandom_range(0, 255);
        endcase
        add_cfg(REG_THRESHOLD, CFG_DATA_W'(v));
      end
      mode = $urandom_range(0, 2);
      lvl  = (plan_beats > RAND_BEATS - TAIL_BEATS) ? 2'd0 : 2'($urandom_range(0, 2));
      add_frame(mode, lvl, 1'b1);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stimulus to run out and every expected pixel to arrive
    do @(negedge clk);
    while (pending.size() != 0 || push || cfg_valid || expected_pixels.size() != 0);
    repeat (20) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
